// ----- rtl/ctlps_pkg.sv -----
`default_nettype none
package ctlps_pkg;

  // request codes
  localparam logic REQ_DRIVE = 1'b0;
  localparam logic REQ_STEP  = 1'b1;

  // register indexes
  localparam logic REG_OUTFLOW_COEFF = 1'b0;
  localparam logic REG_INV_SHAPE     = 1'b1;

  // reset values at Q16.16 (the level as an integer), rescaled to the fraction width at elaboration
  localparam logic [31:0] OUTFLOW_COEFF_Q16 = 32'd911966;
  localparam logic [31:0] INV_SHAPE_Q16     = 32'd62582;
  localparam logic [31:0] INFLOW_Q16        = 32'd2412838;
  localparam logic [31:0] LEVEL_INT         = 32'd7;

  // wide product accumulator and quotient widths
  localparam int unsigned AccW = 128;
  localparam int unsigned QW   = 33;

  typedef enum logic [7:0] {
    ST_IDLE = 8'b0000_0001,
    ST_ROOT = 8'b0000_0010,
    ST_OUTF = 8'b0000_0100,
    ST_NET  = 8'b0000_1000,
    ST_MULT = 8'b0001_0000,
    ST_DCHK = 8'b0010_0000,
    ST_DIV  = 8'b0100_0000,
    ST_DONE = 8'b1000_0000
  } state_e;

  typedef struct packed {
    logic       drive_upd;
    logic       zero_upd;
    logic       root_init;
    logic       root_step;
    logic       outf;
    logic       net;
    logic       mul_pp;
    logic       mul_add;
    logic [1:0] mul_k;
    logic       div_chk;
    logic       div_step;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic lvl_zero;
    logic out_busy;
  } status_t;

endpackage
`default_nettype wire

// ----- rtl/ctlps_ctrl.sv -----
`default_nettype none
module ctlps_ctrl import ctlps_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_ready_o,
  input  wire logic    req_type_i,
  input  wire status_t status_i,
  output cmd_t         cmd_o
);

  localparam int unsigned SW    = (32 + FRAC_BITS + 1) / 2;
  localparam int unsigned CntW  = 6;
  localparam logic [CntW-1:0] RootLast = CntW'(SW - 1);
  localparam logic [CntW-1:0] DivLast  = CntW'(QW - 1);
  localparam logic [CntW-1:0] MulLast  = CntW'(4);

  state_e          state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            in_acc;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i & in_ready_o;

  // sequencer
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    cmd_o.mul_k = cnt_q[1:0];
    case (state_q)
      ST_IDLE: begin
        cnt_d = '0;
        if (in_acc) begin
          if (req_type_i == REQ_DRIVE) begin
            cmd_o.drive_upd = 1'b1;
            state_d = ST_DONE;
          end else if (status_i.lvl_zero) begin
            cmd_o.zero_upd = 1'b1;
            state_d = ST_DONE;
          end else begin
            cmd_o.root_init = 1'b1;
            state_d = ST_ROOT;
          end
        end
      end
      ST_ROOT: begin
        cmd_o.root_step = 1'b1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == RootLast) begin
          state_d = ST_OUTF;
        end
      end
      ST_OUTF: begin
        cmd_o.outf = 1'b1;
        state_d = ST_NET;
      end
      ST_NET: begin
        cmd_o.net = 1'b1;
        cnt_d = '0;
        state_d = ST_MULT;
      end
      ST_MULT: begin
        cmd_o.mul_pp  = (cnt_q != MulLast);
        cmd_o.mul_add = (cnt_q != '0);
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == MulLast) begin
          state_d = ST_DCHK;
        end
      end
      ST_DCHK: begin
        cmd_o.div_chk = 1'b1;
        cnt_d = '0;
        state_d = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == DivLast) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!status_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/ctlps_dp.sv -----
`default_nettype none
module ctlps_dp import ctlps_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_index_i,
  input  wire logic [31:0] cfg_data_i,
  input  wire logic [31:0] drive_change_i,
  input  wire logic [31:0] time_step_i,
  input  wire cmd_t        cmd_i,
  output status_t          status_o,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [31:0]      level_o,
  output logic [31:0]      drive_o,
  output logic             saturated_o
);

  localparam int unsigned XW  = 32 + FRAC_BITS;
  localparam int unsigned SW  = (XW + 1) / 2;
  localparam int unsigned XPW = 2 * SW;
  localparam int unsigned OW  = 32 + SW - FRAC_BITS;
  localparam logic [63:0] CoefRst = (64'(OUTFLOW_COEFF_Q16) << FRAC_BITS) >> 16;
  localparam logic [63:0] ShpRst  = (64'(INV_SHAPE_Q16) << FRAC_BITS) >> 16;
  localparam logic [63:0] InflRst = (64'(INFLOW_Q16) << FRAC_BITS) >> 16;
  localparam logic [63:0] LvlRst  = 64'(LEVEL_INT) << FRAC_BITS;
  localparam logic [63:0] PerRst  = 64'd1 << FRAC_BITS;
  localparam logic [31:0] Max32   = '1;

  logic [31:0]     lvl_q, infl_q, per_q, coef_q, shp_q;
  logic            sat_q;
  logic [XPW-1:0]  x_q;
  logic [SW+1:0]   rem_q;
  logic [SW-1:0]   root_q;
  logic [OW-1:0]   outq_q;
  logic [63:0]     prd_q, dsq_q, m_q, pp_q, drem_q;
  logic            pos_q, big_q;
  logic [1:0]      sh_q;
  logic [AccW-1:0] acc_q;
  logic [QW-1:0]   nlo_q, quo_q;
  logic            out_valid_q;
  logic            fin_en_q;

  // drive change: signed increment with clamp at both ends
  logic [32:0] dmag, dsum;
  logic [31:0] infl_new;
  always_comb begin
    dmag = {1'b0, ~drive_change_i} + 33'd1;
    dsum = {1'b0, infl_q} + {1'b0, drive_change_i};
    if (drive_change_i[31]) begin
      infl_new = (dmag >= {1'b0, infl_q}) ? '0 : 32'(33'(infl_q) - dmag);
    end else begin
      infl_new = dsum[32] ? Max32 : dsum[31:0];
    end
  end

  // one square root digit per cycle
  logic [SW+3:0] r2, trial;
  logic          rbit;
  always_comb begin
    r2    = {rem_q, x_q[XPW-1 -: 2]};
    trial = {2'b00, root_q, 2'b01};
    rbit  = (r2 >= trial);
  end

  // multiplications and net flow
  logic [31+SW:0] coef_prod;
  logic [OW-1:0]  infl_w;
  logic [31:0]    pp_a, pp_b;
  logic [AccW-1:0] pp_sh;
  assign coef_prod = coef_q * root_q;
  assign infl_w    = OW'(infl_q);
  assign pp_a      = cmd_i.mul_k[0] ? prd_q[63:32] : prd_q[31:0];
  assign pp_b      = cmd_i.mul_k[1] ? m_q[63:32] : m_q[31:0];
  assign pp_sh     = AccW'(pp_q) << (7'd32 * (7'(sh_q[0]) + 7'(sh_q[1])));

  // division step on a 65 bit partial remainder
  logic [64:0] d2;
  logic        qbit;
  assign d2   = {drem_q, nlo_q[QW-1]};
  assign qbit = (d2 >= {1'b0, dsq_q});

  // final level with saturation
  logic [33:0] up_sum;
  assign up_sum = 34'(lvl_q) + 34'(quo_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lvl_q       <= LvlRst[31:0];
      infl_q      <= InflRst[31:0];
      per_q       <= PerRst[31:0];
      coef_q      <= CoefRst[31:0];
      shp_q       <= ShpRst[31:0];
      sat_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == REG_OUTFLOW_COEFF) begin
          coef_q <= cfg_data_i;
        end else begin
          shp_q <= cfg_data_i;
        end
      end
      if (cmd_i.drive_upd) begin
        infl_q <= infl_new;
        per_q  <= time_step_i;
        sat_q  <= 1'b0;
      end
      if (cmd_i.zero_upd) begin
        lvl_q <= (infl_q != '0) ? Max32 : '0;
        sat_q <= 1'b1;
      end
      if (cmd_i.root_init) begin
        sat_q <= 1'b0;
      end
      if (cmd_i.out_load && !cmd_i.zero_upd && fin_en_q) begin
        if (pos_q) begin
          if (big_q || up_sum > 34'(Max32)) begin
            lvl_q <= Max32;
            sat_q <= 1'b1;
          end else begin
            lvl_q <= up_sum[31:0];
          end
        end else begin
          if (big_q || quo_q > QW'(lvl_q)) begin
            lvl_q <= '0;
            sat_q <= 1'b1;
          end else begin
            lvl_q <= 32'(QW'(lvl_q) - quo_q);
          end
        end
      end
      // output register
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // marks a step item whose level is applied when the result is loaded
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fin_en_q <= 1'b0;
    end else if (cmd_i.root_init) begin
      fin_en_q <= 1'b1;
    end else if (cmd_i.out_load) begin
      fin_en_q <= 1'b0;
    end
  end

  // result payload follows the level update in the same load
  logic [31:0] lvl_fin;
  logic        sat_fin;
  always_comb begin
    lvl_fin = lvl_q;
    sat_fin = sat_q;
    if (fin_en_q) begin
      if (pos_q) begin
        if (big_q || up_sum > 34'(Max32)) begin
          lvl_fin = Max32;
          sat_fin = 1'b1;
        end else begin
          lvl_fin = up_sum[31:0];
        end
      end else if (big_q || quo_q > QW'(lvl_q)) begin
        lvl_fin = '0;
        sat_fin = 1'b1;
      end else begin
        lvl_fin = 32'(QW'(lvl_q) - quo_q);
      end
    end
  end

  // arithmetic registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.root_init) begin
      x_q    <= XPW'(lvl_q) << FRAC_BITS;
      rem_q  <= '0;
      root_q <= '0;
    end
    if (cmd_i.root_step) begin
      x_q    <= x_q << 2;
      rem_q  <= rbit ? (SW+2)'(r2 - trial) : r2[SW+1:0];
      root_q <= {root_q[SW-2:0], rbit};
    end
    if (cmd_i.outf) begin
      outq_q <= OW'(coef_prod >> FRAC_BITS);
      prd_q  <= per_q * shp_q;
      dsq_q  <= lvl_q * lvl_q;
    end
    if (cmd_i.net) begin
      pos_q <= (infl_w >= outq_q);
      m_q   <= (infl_w >= outq_q) ? 64'(infl_w - outq_q) : 64'(outq_q - infl_w);
      acc_q <= '0;
    end
    if (cmd_i.mul_pp) begin
      pp_q <= pp_a * pp_b;
      sh_q <= cmd_i.mul_k;
    end
    if (cmd_i.mul_add) begin
      acc_q <= acc_q + pp_sh;
    end
    if (cmd_i.div_chk) begin
      big_q  <= ((acc_q >> QW) >= AccW'(dsq_q));
      drem_q <= acc_q[QW +: 64];
      nlo_q  <= acc_q[QW-1:0];
      quo_q  <= '0;
    end
    if (cmd_i.div_step) begin
      drem_q <= qbit ? 64'(d2 - {1'b0, dsq_q}) : d2[63:0];
      nlo_q  <= nlo_q << 1;
      quo_q  <= {quo_q[QW-2:0], qbit};
    end
    if (cmd_i.out_load) begin
      level_o     <= lvl_fin;
      drive_o     <= infl_q;
      saturated_o <= sat_fin;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign status_o.lvl_zero = (lvl_q == '0);
  assign status_o.out_busy = out_valid_q & ~out_ready_i;

endmodule
`default_nettype wire

// ----- rtl/conical_tank_level_plant_step.sv -----
`default_nettype none
// Tank level plant step.
// Input channel (in_valid_i / in_ready_o) carries one item: req_type_i selects
// a drive change (0: add drive_change_i to the inflow, store time_step_i) or a
// level step (1). Every item yields one result on the output channel
// (out_valid_o / out_ready_i): level_o, drive_o and saturated_o.
// Configuration writes (cfg_valid_i / cfg_ready_o) set outflow_coeff (index 0)
// or inv_shape (index 1); they are always taken and belong between items.
// One item is worked at a time. A drive item updates the inflow when it is
// accepted and passes straight to the load. A level step runs the square root one
// digit per cycle, then an outflow and a net flow setup step, four 32x32 partial
// products accumulated in turn, one range check, a 33-bit restoring divide
// and the load. Values are Q16.16 at the default FRAC_BITS.
// A step on an empty tank skips the arithmetic and goes straight to the load.
// A new item is taken as soon as the sequencer is idle, even while the last
// result still waits; a stalled receiver holds the next result in the
// sequencer until the output register frees.
// Reset restores level 7.0, the equilibrium inflow, period 1.0 and the
// default coefficients, and leaves the output channel empty.
module conical_tank_level_plant_step import ctlps_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic        cfg_index_i,
  input  wire logic [31:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        req_type_i,
  input  wire logic [31:0] drive_change_i,
  input  wire logic [31:0] time_step_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [31:0]      level_o,
  output logic [31:0]      drive_o,
  output logic             saturated_o
);

  cmd_t    cmd;
  status_t status;

  assign cfg_ready_o = 1'b1;

  ctlps_ctrl #(.FRAC_BITS(FRAC_BITS)) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .req_type_i (req_type_i),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  ctlps_dp #(.FRAC_BITS(FRAC_BITS)) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_valid_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .drive_change_i (drive_change_i),
    .time_step_i    (time_step_i),
    .cmd_i          (cmd),
    .status_o       (status),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .level_o        (level_o),
    .drive_o        (drive_o),
    .saturated_o    (saturated_o)
  );

endmodule
`default_nettype wire

// ----- test/conical_tank_level_plant_step_check.sv -----
`timescale 1ns / 100ps
module conical_tank_level_plant_step_check import ctlps_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic        cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic        req_type_i,
  input  logic [31:0] drive_change_i,
  input  logic [31:0] time_step_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [31:0] level_i,
  input  logic [31:0] drive_i,
  input  logic        saturated_i,
  output int          pending_o,
  output int          errors_o
);

  typedef struct packed {
    logic [31:0] level;
    logic [31:0] drive;
    logic        saturated;
  } plant_out_t;

  localparam logic [63:0] MAX32 = 64'hFFFF_FFFF;

  // plant state mirror
  logic [31:0] coeff_q, shape_q, level_q, inflow_q, period_q;
  plant_out_t  plant_out_q[$];
  int          errors;

  assign pending_o = plant_out_q.size();
  assign errors_o  = errors;

  function automatic logic [31:0] root_floor(input logic [63:0] x);
    logic [31:0] r;
    logic [31:0] t;
    r = '0;
    for (int b = 31; b >= 0; b--) begin
      t = r | (32'd1 << b);
      if ({32'd0, t} * {32'd0, t} <= x) r = t;
    end
    return r;
  endfunction

  // advance the mirrored state by one transaction and return its result
  function automatic plant_out_t plant_advance(input logic rt, input logic [31:0] dc,
                                               input logic [31:0] ts);
    plant_out_t   r;
    logic [63:0]  lv, s, outq, m, d, q, ps;
    logic [127:0] prod, quo;
    logic [32:0]  mag;
    logic         pos;
    r.saturated = 1'b0;
    if (rt == REQ_DRIVE) begin
      if (dc[31]) begin
        mag = {1'b0, ~dc} + 33'd1;
        inflow_q = (mag >= {1'b0, inflow_q}) ? 32'd0 : inflow_q - mag[31:0];
      end else begin
        inflow_q = ({32'd0, inflow_q} + {32'd0, dc} > MAX32) ? 32'hFFFF_FFFF
                                                              : inflow_q + dc;
      end
      period_q = ts;
    end else if (level_q == 0) begin
      r.saturated = 1'b1;
      level_q = (inflow_q != 0) ? 32'hFFFF_FFFF : 32'd0;
    end else begin
      lv   = {32'd0, level_q};
      s    = {32'd0, root_floor(lv << FRAC_BITS)};
      outq = ({32'd0, coeff_q} * s) >> FRAC_BITS;
      pos  = {32'd0, inflow_q} >= outq;
      m    = pos ? {32'd0, inflow_q} - outq : outq - {32'd0, inflow_q};
      ps   = {32'd0, period_q} * {32'd0, shape_q};
      prod = {64'd0, ps} * {64'd0, m};
      d    = lv * lv;
      quo  = prod / {64'd0, d};
      q    = (quo[127:64] != 0) ? 64'hFFFF_FFFF_FFFF_FFFF : quo[63:0];
      if (pos) begin
        if (q > MAX32 - lv) begin
          level_q = 32'hFFFF_FFFF;
          r.saturated = 1'b1;
        end else begin
          level_q = 32'(lv + q);
        end
      end else if (q > lv) begin
        level_q = 32'd0;
        r.saturated = 1'b1;
      end else begin
        level_q = 32'(lv - q);
      end
    end
    r.level = level_q;
    r.drive = inflow_q;
    return r;
  endfunction

  // predict on accepted inputs, compare on accepted results
  always @(posedge clk_i or negedge rst_ni) begin
    plant_out_t e;
    if (!rst_ni) begin
      coeff_q  <= 32'((64'(OUTFLOW_COEFF_Q16) << FRAC_BITS) >> 16);
      shape_q  <= 32'((64'(INV_SHAPE_Q16) << FRAC_BITS) >> 16);
      level_q  <= LEVEL_INT << FRAC_BITS;
      inflow_q <= 32'((64'(INFLOW_Q16) << FRAC_BITS) >> 16);
      period_q <= 32'd1 << FRAC_BITS;
      plant_out_q.delete();
      errors   <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == REG_OUTFLOW_COEFF) coeff_q = cfg_data_i;
        else if (cfg_index_i == REG_INV_SHAPE) shape_q = cfg_data_i;
      end
      if (in_valid_i && in_ready_i)
        plant_out_q.push_back(plant_advance(req_type_i, drive_change_i, time_step_i));
      if (out_valid_i && out_ready_i) begin
        if (plant_out_q.size() == 0) begin
          $display("%0t: result with nothing expected: level %h drive %h sat %b",
                   $time, level_i, drive_i, saturated_i);
          errors <= errors + 1;
        end else begin
          e = plant_out_q.pop_front();
          if (e.level !== level_i || e.drive !== drive_i || e.saturated !== saturated_i) begin
            $display("%0t: mismatch level exp %h got %h, drive exp %h got %h, sat exp %b got %b",
                     $time, e.level, level_i, e.drive, drive_i, e.saturated, saturated_i);
            errors <= errors + 1;
          end
        end
      end
    end
  end

endmodule

// ----- test/conical_tank_level_plant_step_test.sv -----
`timescale 1ns / 100ps
module conical_tank_level_plant_step_test import ctlps_pkg::*;;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid = 1'b0, cfg_ready, cfg_index = 1'b0;
  logic [31:0] cfg_data = '0;
  logic        in_valid = 1'b0, in_ready, req_type = 1'b0;
  logic [31:0] drive_change = '0, time_step = '0;
  logic        out_valid, out_ready = 1'b0;
  logic [31:0] level, drive;
  logic        saturated;
  int          pending, errors;
  logic        no_idle = 1'b0;
  logic        hold_req = 1'b0;
  int          quiet_cycles = 0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  conical_tank_level_plant_step dut (
    .clk_i, .rst_ni,
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready), .cfg_index_i(cfg_index),
    .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_ready_o(in_ready), .req_type_i(req_type),
    .drive_change_i(drive_change), .time_step_i(time_step),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .level_o(level), .drive_o(drive), .saturated_o(saturated)
  );

  conical_tank_level_plant_step_check check (
    .clk_i, .rst_ni,
    .cfg_valid_i(cfg_valid), .cfg_ready_i(cfg_ready), .cfg_index_i(cfg_index),
    .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_ready_i(in_ready), .req_type_i(req_type),
    .drive_change_i(drive_change), .time_step_i(time_step),
    .out_valid_i(out_valid), .out_ready_i(out_ready),
    .level_i(level), .drive_i(drive), .saturated_i(saturated),
    .pending_o(pending), .errors_o(errors)
  );

  // send one transaction, keeping valid high across back-to-back items
  task automatic send_item(input logic rt, input logic [31:0] dc, input logic [31:0] ts);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid     <= 1'b1;
    req_type     <= rt;
    drive_change <= dc;
    time_step    <= ts;
    do @(posedge clk_i); while (!in_ready);
  endtask

  // drop valid and let the last accepted transaction count as pending first
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // valid stays high for a following write; the caller drops it
  task automatic write_reg(input logic idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk_i); while (!cfg_ready);
  endtask

  // mostly plausible plant traffic, some fully random noise
  task automatic random_item();
    logic [31:0] dc;
    if ($urandom_range(0, 9) == 0) begin
      send_item(1'($urandom_range(0, 1)), $urandom, $urandom);
    end else if ($urandom_range(0, 3) == 0) begin
      dc = $urandom_range(0, 32'h4_0000);
      if ($urandom_range(0, 1)) dc = -dc;
      send_item(REQ_DRIVE, dc, $urandom_range(0, 32'h2_0000));
    end else begin
      send_item(REQ_STEP, $urandom, $urandom);
    end
  endtask

  // result side: random stalls, optional long hold-off
  initial begin
    int gap;
    @(posedge rst_ni);
    forever begin
      gap = no_idle ? 0 : $urandom_range(0, 12);
      if (hold_req) begin
        gap = 400;
        hold_req <= 1'b0;
      end
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready <= 1'b1;
      do @(posedge clk_i); while (!out_valid);
    end
  end

  // watchdog on cycles with no transaction
  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 5000) begin
      $display("conical_tank_level_plant_step test failed");
      $finish;
    end
  end

  initial begin
    logic [31:0] coeffs [5];
    logic [31:0] shapes [5];
    coeffs = '{32'd911966, 32'd0, 32'hFFFF_FFFF, $urandom_range(0, 32'h20_0000), $urandom};
    shapes = '{32'd62582, 32'd0, 32'hFFFF_FFFF, $urandom_range(0, 32'h2_0000), $urandom};
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: rails of inflow and level, empty tank both ways
    send_item(REQ_STEP, '0, '0);
    send_item(REQ_DRIVE, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    send_item(REQ_DRIVE, 32'h7FFF_FFFF, 32'h0001_0000);
    send_item(REQ_STEP, '0, '0);
    send_item(REQ_STEP, '0, '0);
    send_item(REQ_DRIVE, 32'h8000_0000, 32'hFFFF_FFFF);
    send_item(REQ_DRIVE, 32'h8000_0000, 32'hFFFF_FFFF);
    send_item(REQ_STEP, '0, '0);
    send_item(REQ_STEP, '0, '0);
    send_item(REQ_STEP, '0, '0);
    send_item(REQ_DRIVE, 32'h0000_0001, 32'h0000_0000);
    send_item(REQ_STEP, '0, '0);
    send_item(REQ_DRIVE, 32'hFFFF_FFFF, 32'h0000_8000);
    send_item(REQ_STEP, '0, '0);
    send_item(REQ_DRIVE, 32'h0000_0000, 32'h0001_0000);
    send_item(REQ_DRIVE, 32'h0024_D126, 32'h0001_0000);
    send_item(REQ_STEP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    drain();

    // phases over register settings
    for (int p = 0; p < 5; p++) begin
      write_reg(REG_OUTFLOW_COEFF, coeffs[p]);
      write_reg(REG_INV_SHAPE, shapes[p]);
      cfg_valid <= 1'b0;
      no_idle <= (p == 3);
      for (int i = 0; i < 80; i++) begin
        if (p == 2 && i == 10) hold_req <= 1'b1;
        if (p == 4 && i == 40) drain();
        random_item();
      end
      drain();
    end
    no_idle <= 1'b0;

    repeat (100) @(posedge clk_i);
    if (errors == 0)
      $display("conical_tank_level_plant_step test passed");
    else
      $display("conical_tank_level_plant_step test failed");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/ctlps_pkg.sv
rtl/ctlps_ctrl.sv
rtl/ctlps_dp.sv
rtl/conical_tank_level_plant_step.sv
test/conical_tank_level_plant_step_check.sv
test/conical_tank_level_plant_step_test.sv
